// ===== rtl/core/bb3ea_pkg.sv =====
// Package for the edge-aware 3x3 box blur: constants, payload structs and the
// command/status structs between controller and datapath. No dependencies.

package bb3ea_pkg;

  localparam int unsigned MaxWidthDefault  = 1024;
  localparam int unsigned MaxHeightDefault = 1024;

  localparam int unsigned CfgW     = 11;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned PixW     = 3 * ChanW;
  localparam int unsigned SumW     = 12;
  localparam int unsigned NumW     = 13;
  localparam int unsigned CntW     = 4;
  localparam int unsigned DivSteps = 8;
  localparam int unsigned DsrW     = CntW + DivSteps;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CfgW-1:0] ImageWidthReset  = 11'd1024;
  localparam logic [CfgW-1:0] ImageHeightReset = 11'd1024;

  typedef struct packed {
    logic             operation;
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic             frame_last;
  } blur_out_t;

  typedef struct packed {
    logic accept;
    logic read;
    logic sum;
    logic shift;
    logic div_step;
    logic load_out;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic emits;
    logic edge_hit;
    logic is_flush;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/bb3ea_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the two line stores. No dependencies.

module bb3ea_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bb3ea_ctrl.sv =====
// Controller state machine of the box blur: sequences read, window shift,
// sum, divide and output per transfer. Depends on bb3ea_pkg.

module bb3ea_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  bb3ea_pkg::dp_status_t  status_i,
  output bb3ea_pkg::dp_cmd_t     cmd_o
);
  import bb3ea_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_READ     = 8'b0000_0010,
    S_SUM_PRE  = 8'b0000_0100,
    S_SHIFT    = 8'b0000_1000,
    S_SUM_POST = 8'b0001_0000,
    S_DIV      = 8'b0010_0000,
    S_OUT      = 8'b0100_0000,
    S_END      = 8'b1000_0000
  } state_e;

  localparam int unsigned DivCntW = $clog2(DivSteps);

  state_e             state_q, state_d;
  logic [1:0]         guard_q, guard_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;

  always_comb begin
    state_d   = state_q;
    guard_d   = guard_q;
    div_cnt_d = '0;
    cmd_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          guard_d      = '0;
          if (!status_i.skip) begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = status_i.edge_hit ? S_SUM_PRE : S_SHIFT;
      end
      S_SUM_PRE: begin
        cmd_o.sum = 1'b1;
        state_d   = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (status_i.emits) begin
          state_d = status_i.edge_hit ? S_DIV : S_SUM_POST;
        end else if (status_i.is_flush && guard_q != 2'd2) begin
          guard_d = guard_q + 2'd1;
          state_d = S_READ;
        end else if (status_i.is_flush) begin
          state_d = S_OUT;
        end else begin
          state_d = S_END;
        end
      end
      S_SUM_POST: begin
        cmd_o.sum = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + DivCntW'(1);
        if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_END;
        end
      end
      S_END: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      guard_q   <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      guard_q   <= guard_d;
      div_cnt_q <= div_cnt_d;
    end
  end

endmodule

// ===== rtl/core/bb3ea_datapath.sv =====
// Datapath of the box blur: size registers, position counters, line stores,
// 3x3 window, masked sum, iterative divider and output register.
// Depends on bb3ea_pkg and bb3ea_ram.

module bb3ea_datapath #(
  parameter int unsigned MAX_WIDTH  = bb3ea_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = bb3ea_pkg::MaxHeightDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bb3ea_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bb3ea_pkg::CfgW-1:0]        cfg_data_i,
  input  bb3ea_pkg::pixel_in_t              in_data_i,
  input  bb3ea_pkg::dp_cmd_t                cmd_i,
  output bb3ea_pkg::dp_status_t             status_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output bb3ea_pkg::blur_out_t              out_data_o
);
  import bb3ea_pkg::*;

  localparam int unsigned AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned DimW  = $clog2(MAX_WIDTH + 2);
  localparam int unsigned HgtW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RowW  = $clog2(MAX_HEIGHT + 4);

  logic [CfgW-1:0]  width_q, width_d, height_q, height_d;
  logic [DimW-1:0]  eff_w;
  logic [HgtW-1:0]  eff_h;

  logic [AddrW-1:0] arr_col_q, arr_col_d, emit_col_q, emit_col_d;
  logic [RowW-1:0]  arr_row_q, arr_row_d, emit_row_q, emit_row_d;
  logic [DimW-1:0]  pending_q, pending_d;

  pixel_in_t        item_q, item_d;
  logic [PixW-1:0]  px;
  logic [PixW-1:0]  older_rdata, newer_rdata;
  logic [2:0][2:0][PixW-1:0] win_q, win_d;

  logic             emits, edge_hit, arr_col_last, emit_col_last, top_in, bot_in;
  logic [1:0]       col_lo, nrows, ncols;
  logic [2:0]       row_in;
  logic [8:0]       mask;
  logic [CntW-1:0]  count;
  logic             frame_last;

  logic [8:0]       mask_q, mask_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             emits_q, emits_d, last_q, last_d;

  logic [2:0][SumW-1:0]  sum;
  logic [2:0][NumW-1:0]  rem_q, rem_d;
  logic [2:0][ChanW-1:0] quo_q, quo_d;
  logic [DsrW-1:0]       dsr_q, dsr_d;

  logic       out_valid_q, out_valid_d;
  blur_out_t  out_data_q, out_data_d;

  always_comb begin
    if (width_q == '0) begin
      eff_w = DimW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = DimW'(MAX_WIDTH);
    end else begin
      eff_w = DimW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HgtW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      eff_h = HgtW'(MAX_HEIGHT);
    end else begin
      eff_h = HgtW'(height_q);
    end
  end

  assign arr_col_last  = (DimW'(arr_col_q) + DimW'(1)) >= eff_w;
  assign emit_col_last = (DimW'(emit_col_q) + DimW'(1)) >= eff_w;
  assign emits    = (arr_row_q >= RowW'(2)) || (arr_row_q == RowW'(1) && arr_col_q != '0);
  assign edge_hit = emits && emit_col_last;
  assign top_in   = (emit_row_q != '0);
  assign bot_in   = (32'(emit_row_q) + 32'd1) < 32'(eff_h);
  assign row_in   = {bot_in, 1'b1, top_in};
  assign frame_last = ((32'(emit_row_q) + 32'd1) >= 32'(eff_h)) && emit_col_last;

  always_comb begin
    if (edge_hit) begin
      col_lo = (eff_w >= DimW'(2)) ? 2'd1 : 2'd2;
    end else begin
      col_lo = (emit_col_q != '0) ? 2'd0 : 2'd1;
    end
    nrows = 2'd1 + {1'b0, top_in} + {1'b0, bot_in};
    ncols = 2'd3 - col_lo;
    count = CntW'(nrows) * CntW'(ncols);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mask[r*3+c] = row_in[r] && (2'(c) >= col_lo);
      end
    end
  end

  assign px = (item_q.operation == OP_FLUSH) ? '0
            : {item_q.red_in, item_q.green_in, item_q.blue_in};

  bb3ea_ram #(
    .Width (PixW),
    .Depth (MAX_WIDTH)
  ) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.shift),
    .waddr_i (arr_col_q),
    .wdata_i (newer_rdata),
    .re_i    (cmd_i.read),
    .raddr_i (arr_col_q),
    .rdata_o (older_rdata)
  );

  bb3ea_ram #(
    .Width (PixW),
    .Depth (MAX_WIDTH)
  ) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.shift),
    .waddr_i (arr_col_q),
    .wdata_i (px),
    .re_i    (cmd_i.read),
    .raddr_i (arr_col_q),
    .rdata_o (newer_rdata)
  );

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (mask_q[r*3+c]) begin
            sum[ch] = sum[ch] + SumW'(win_q[r][c][ChanW*(2-ch) +: ChanW]);
          end
        end
      end
    end
  end

  always_comb begin
    width_d    = width_q;
    height_d   = height_q;
    arr_col_d  = arr_col_q;
    arr_row_d  = arr_row_q;
    emit_col_d = emit_col_q;
    emit_row_d = emit_row_q;
    pending_d  = pending_q;
    item_d     = item_q;
    win_d      = win_q;
    mask_d     = mask_q;
    count_d    = count_q;
    emits_d    = emits_q;
    last_d     = last_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    dsr_d      = dsr_q;
    out_data_d = out_data_q;
    out_valid_d = out_valid_q;

    if (cmd_i.accept) begin
      item_d = in_data_i;
    end

    if (cmd_i.read) begin
      mask_d  = mask;
      count_d = count;
      emits_d = emits;
      last_d  = frame_last;
    end

    if (cmd_i.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r][0] = win_q[r][1];
        win_d[r][1] = win_q[r][2];
      end
      win_d[0][2] = older_rdata;
      win_d[1][2] = newer_rdata;
      win_d[2][2] = px;
      if (arr_col_last) begin
        arr_col_d = '0;
        arr_row_d = arr_row_q + RowW'(1);
      end else begin
        arr_col_d = arr_col_q + AddrW'(1);
      end
      if (emits) begin
        if (emit_col_last) begin
          emit_col_d = '0;
          emit_row_d = emit_row_q + RowW'(1);
        end else begin
          emit_col_d = emit_col_q + AddrW'(1);
        end
      end
    end

    if (cmd_i.sum) begin
      for (int ch = 0; ch < 3; ch++) begin
        rem_d[ch] = NumW'({sum[ch], 1'b0}) + NumW'(count_q);
        quo_d[ch] = '0;
      end
      dsr_d = DsrW'({count_q, {DivSteps{1'b0}}});
    end

    if (cmd_i.div_step) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (rem_q[ch] >= NumW'(dsr_q)) begin
          rem_d[ch] = rem_q[ch] - NumW'(dsr_q);
          quo_d[ch] = {quo_q[ch][ChanW-2:0], 1'b1};
        end else begin
          quo_d[ch] = {quo_q[ch][ChanW-2:0], 1'b0};
        end
      end
      dsr_d = dsr_q >> 1;
    end

    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
      if (emits_q) begin
        out_data_d = '{red_out: quo_q[0], green_out: quo_q[1], blue_out: quo_q[2],
                       frame_last: last_q};
      end else begin
        out_data_d = '0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.finish) begin
      if (item_q.operation == OP_PIXEL) begin
        if (32'(arr_row_q) >= 32'(eff_h)) begin
          pending_d = (eff_h == HgtW'(1)) ? eff_w : eff_w + DimW'(1);
        end
      end else if (pending_q == DimW'(1)) begin
        pending_d  = '0;
        arr_col_d  = '0;
        arr_row_d  = '0;
        emit_col_d = '0;
        emit_row_d = '0;
      end else begin
        pending_d = pending_q - DimW'(1);
      end
    end

    if (cfg_we_i) begin
      if (cfg_index_i == CFG_IMAGE_WIDTH) begin
        width_d = cfg_data_i;
      end else begin
        height_d = cfg_data_i;
      end
      pending_d  = '0;
      arr_col_d  = '0;
      arr_row_d  = '0;
      emit_col_d = '0;
      emit_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= ImageWidthReset;
      height_q    <= ImageHeightReset;
      arr_col_q   <= '0;
      arr_row_q   <= '0;
      emit_col_q  <= '0;
      emit_row_q  <= '0;
      pending_q   <= '0;
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      arr_col_q   <= arr_col_d;
      arr_row_q   <= arr_row_d;
      emit_col_q  <= emit_col_d;
      emit_row_q  <= emit_row_d;
      pending_q   <= pending_d;
      win_q       <= win_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    mask_q     <= mask_d;
    count_q    <= count_d;
    emits_q    <= emits_d;
    last_q     <= last_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    dsr_q      <= dsr_d;
    out_data_q <= out_data_d;
  end

  assign status_o.skip     = (in_data_i.operation == OP_PIXEL) ? (pending_q != '0)
                                                               : (pending_q == '0);
  assign status_o.emits    = emits;
  assign status_o.edge_hit = edge_hit;
  assign status_o.is_flush = (item_q.operation == OP_FLUSH);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/box_blur_3x3_edge_aware.sv =====
// Edge-aware 3x3 box blur over an RGB raster stream.
// Input channel (in_valid_i/in_ready_o, in_data_i): one transfer is either a
// pixel in raster order or a flush tick. The blurred pixel at raster index p
// leaves with the input transfer of index p+width+1; after the frame's last
// pixel, each flush tick releases one pending result, and frame_last marks
// the final one. Pixels sent while results are still pending are dropped.
// Output channel (out_valid_o/out_ready_i, out_data_o): zero or one result
// per input transfer, held in an output register.
// Sequencing: a transfer is finished before the next one can be accepted; one
// that yields a result runs the line-store read, window shift and sum, then
// the 8-step restoring divider, at the right image edge too; one that yields
// none runs only the read and shift; a flush tick may run extra virtual
// pixels through read and shift. When the receiver stalls, the block
// finishes the next result and then waits until the output register frees.
// Reset clears positions, window and pending count and sets width and
// height to 1024; the line-store contents are not cleared. Depends on
// bb3ea_pkg, bb3ea_ctrl, bb3ea_datapath and bb3ea_ram.

module box_blur_3x3_edge_aware #(
  parameter int unsigned MAX_WIDTH  = bb3ea_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = bb3ea_pkg::MaxHeightDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bb3ea_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bb3ea_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bb3ea_pkg::pixel_in_t          in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bb3ea_pkg::blur_out_t          out_data_o
);
  import bb3ea_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bb3ea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bb3ea_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> status.out_free)
    else $error("Result loaded while the output register still holds a transfer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.read |=> (cmd.shift || cmd.sum))
    else $error("Line-store read not followed by a window shift or sum.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> in_ready_o)
    else $error("Block not ready for input after finishing a transfer.");
`endif

endmodule

// ===== sim/tb_box_blur_3x3_edge_aware.sv =====
// Self-checking testbench for the edge-aware 3x3 box blur: a scoreboard class predicts
// each blurred pixel from the accepted transfers, and plain tasks drive the ports.
// Depends on bb3ea_pkg and box_blur_3x3_edge_aware.

import bb3ea_pkg::*;

class blur_scoreboard;
  logic [PixW-1:0] older_line [MaxWidthDefault];
  logic [PixW-1:0] newer_line [MaxWidthDefault];
  logic [PixW-1:0] win [3][3];
  logic [CfgW-1:0] width_reg;
  logic [CfgW-1:0] height_reg;
  int unsigned in_row, in_col, out_row, out_col, drain_left;
  blur_out_t blurred_due [$];
  int unsigned errors;
  int unsigned checked;

  function new();
    foreach (older_line[i]) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    foreach (win[r, c]) win[r][c] = '0;
    width_reg = ImageWidthReset;
    height_reg = ImageHeightReset;
    errors = 0;
    checked = 0;
    restart();
  endfunction

  function void restart();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
    drain_left = 0;
  endfunction

  function int unsigned used_width();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidthDefault) return MaxWidthDefault;
    return width_reg;
  endfunction

  function int unsigned used_height();
    if (height_reg == 0) return 1;
    if (height_reg > MaxHeightDefault) return MaxHeightDefault;
    return height_reg;
  endfunction

  function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
    if (idx == CFG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
    restart();
  endfunction

  function void window_mean(input int unsigned rlo, input int unsigned rhi,
                            input int unsigned clo, inout blur_out_t res);
    int unsigned s_red, s_green, s_blue, cnt;
    s_red = 0;
    s_green = 0;
    s_blue = 0;
    cnt = 0;
    for (int unsigned r = rlo; r <= rhi; r++) begin
      for (int unsigned c = clo; c <= 2; c++) begin
        s_red += win[r][c][23:16];
        s_green += win[r][c][15:8];
        s_blue += win[r][c][7:0];
        cnt++;
      end
    end
    res.red_out = 8'((2 * s_red + cnt) / (2 * cnt));
    res.green_out = 8'((2 * s_green + cnt) / (2 * cnt));
    res.blue_out = 8'((2 * s_blue + cnt) / (2 * cnt));
  endfunction

  // One real or virtual pixel through the line stores and the window.
  function bit advance(input logic [PixW-1:0] px, inout blur_out_t res);
    int unsigned w, h, rlo, rhi, col;
    bit emits, at_edge;
    logic [PixW-1:0] top, mid;
    w = used_width();
    h = used_height();
    emits = (in_row * w + in_col) >= w + 1;
    at_edge = emits && (out_col + 1 >= w);
    rlo = (out_row >= 1) ? 0 : 1;
    rhi = (out_row + 1 < h) ? 2 : 1;
    if (at_edge) window_mean(rlo, rhi, (w >= 2) ? 1 : 2, res);
    col = (in_col >= MaxWidthDefault) ? MaxWidthDefault - 1 : in_col;
    top = older_line[col];
    mid = newer_line[col];
    older_line[col] = mid;
    newer_line[col] = px;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;
    if (emits && !at_edge) window_mean(rlo, rhi, (out_col >= 1) ? 0 : 1, res);
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    if (emits) begin
      res.frame_last = (out_row + 1 >= h) && (out_col + 1 >= w);
      if (out_col + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    end
    return emits;
  endfunction

  function void note_transfer(pixel_in_t item);
    blur_out_t res;
    bit got;
    int unsigned w, total;
    res = '0;
    got = 0;
    w = used_width();
    total = w * used_height();
    if (item.operation == OP_PIXEL) begin
      if (drain_left != 0) return;
      got = advance({item.red_in, item.green_in, item.blue_in}, res);
      if (in_row * w + in_col >= total) drain_left = (total < w + 1) ? total : w + 1;
    end else begin
      if (drain_left == 0) return;
      for (int g = 0; g < 3 && !got; g++) got = advance('0, res);
      if (!got) res = '0;
      got = 1;
      drain_left--;
      if (drain_left == 0) restart();
    end
    if (got) blurred_due.push_back(res);
  endfunction

  function void compare_field(string name, logic [ChanW-1:0] want, logic [ChanW-1:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, seen);
      errors++;
    end
  endfunction

  function void check_result(blur_out_t seen);
    blur_out_t want;
    if (blurred_due.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %p", $time, seen);
      errors++;
      return;
    end
    want = blurred_due.pop_front();
    checked++;
    compare_field("red_out", want.red_out, seen.red_out);
    compare_field("green_out", want.green_out, seen.green_out);
    compare_field("blue_out", want.blue_out, seen.blue_out);
    compare_field("frame_last", ChanW'(want.frame_last), ChanW'(seen.frame_last));
  endfunction
endclass

module tb_box_blur_3x3_edge_aware;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_IMAGE_WIDTH;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  pixel_in_t          in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  blur_out_t          out_data_o;

  blur_scoreboard blur_check;
  int unsigned    sent;
  int unsigned    stall_left = 0;
  bit             gaps_on = 1'b0;
  bit             stall_on = 1'b0;

  always #5 clk_i = ~clk_i;

  box_blur_3x3_edge_aware DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) blur_check.check_result(out_data_o);
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic [ChanW-1:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return ChanW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_in_t random_pixel();
    pixel_in_t p;
    p.operation = OP_PIXEL;
    p.red_in = pick_channel();
    p.green_in = pick_channel();
    p.blue_in = pick_channel();
    return p;
  endfunction

  function automatic pixel_in_t flush_item();
    pixel_in_t p;
    p = random_pixel();
    p.operation = OP_FLUSH;
    return p;
  endfunction

  function automatic pixel_in_t make_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                           logic [ChanW-1:0] b);
    pixel_in_t p;
    p.operation = OP_PIXEL;
    p.red_in = r;
    p.green_in = g;
    p.blue_in = b;
    return p;
  endfunction

  task automatic send(input pixel_in_t item);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_data_i <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    blur_check.note_transfer(item);
    sent++;
  endtask

  task automatic drain_frame(input bit noisy);
    while (blur_check.drain_left != 0) begin
      if (noisy && $urandom_range(0, 9) == 0) send(random_pixel());
      send(flush_item());
    end
  endtask

  task automatic settle();
    int unsigned n;
    in_valid_i <= 1'b0;
    n = 0;
    while (blur_check.blurred_due.size() != 0 && n < 3000) begin
      @(posedge clk_i);
      n++;
    end
    if (blur_check.blurred_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               blur_check.blurred_due.size());
      blur_check.errors += blur_check.blurred_due.size();
      blur_check.blurred_due.delete();
    end
    repeat (30) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_IMAGE_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    blur_check.write_register(CFG_IMAGE_WIDTH, w);
    cfg_index_i <= CFG_IMAGE_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    blur_check.write_register(CFG_IMAGE_HEIGHT, h);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_frame(input bit cut_short);
    int unsigned total, n;
    total = blur_check.used_width() * blur_check.used_height();
    n = cut_short ? $urandom_range(1, total) : total;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) send(flush_item());
      send(random_pixel());
    end
    if (!cut_short) drain_frame(1'b1);
  endtask

  function automatic logic [CfgW-1:0] random_size(int unsigned hi);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CfgW'(1);
      2: return CfgW'($urandom_range(hi + 1, 2 * hi + 4));
      default: return CfgW'($urandom_range(2, hi));
    endcase
  endfunction

  initial begin
    bit cut;
    cut = 1'b1;
    sent = 0;
    blur_check = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure('0, '0);
    send(flush_item());
    send(make_pixel(8'd255, 8'd0, 8'd128));
    send(make_pixel(8'd1, 8'd2, 8'd3));
    send(flush_item());
    send(flush_item());
    settle();
    configure(CfgW'(2), CfgW'(2));
    send(make_pixel(8'd255, 8'd255, 8'd0));
    send(make_pixel(8'd0, 8'd255, 8'd0));
    send(make_pixel(8'd0, 8'd0, 8'd255));
    send(make_pixel(8'd255, 8'd0, 8'd1));
    drain_frame(1'b0);
    settle();
    configure(CfgW'(3), CfgW'(1));
    send(make_pixel(8'd255, 8'd255, 8'd255));
    send(make_pixel(8'd0, 8'd0, 8'd0));
    send(make_pixel(8'd255, 8'd1, 8'd254));
    drain_frame(1'b0);
    settle();
    configure(CfgW'(1), CfgW'(3));
    send(make_pixel(8'd255, 8'd0, 8'd255));
    send(make_pixel(8'd0, 8'd255, 8'd0));
    send(make_pixel(8'd127, 8'd128, 8'd255));
    drain_frame(1'b0);

    settle();
    configure('1, '1);
    repeat (1028) send(random_pixel());

    while (sent < 1600) begin
      if (sent > 1450) begin
        gaps_on = 1'b0;
        stall_on = 1'b0;
      end else begin
        gaps_on = $urandom_range(0, 3) != 0;
        stall_on = $urandom_range(0, 3) != 0;
      end
      if (cut || $urandom_range(0, 2) != 0) begin
        settle();
        configure(random_size(8), random_size(5));
      end
      cut = $urandom_range(0, 5) == 0;
      run_frame(cut);
    end

    settle();
    $display("Sent %0d input transfers and checked %0d blurred pixels,", sent, blur_check.checked);
    $display("over frame sizes from a single pixel up to rows of 1024.");
    if (blur_check.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== box_blur_3x3_edge_aware.f =====
rtl/core/bb3ea_pkg.sv
rtl/core/bb3ea_ram.sv
rtl/core/bb3ea_ctrl.sv
rtl/core/bb3ea_datapath.sv
rtl/core/box_blur_3x3_edge_aware.sv
sim/tb_box_blur_3x3_edge_aware.sv
